### design/ntc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the NTC thermistor thermometer.
// Used by every module of the block; depends on nothing.
package ntc_pkg;

  localparam int ADC_BITS_DEF     = 12;
  localparam int SERIES_TERMS_DEF = 10;
  localparam int MAX_SHIFT_DEF    = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam int Q_FRAC      = 28;
  localparam int R_W         = 24;
  localparam logic [R_W-1:0] R_MAX = 24'hFFFFFF;
  localparam logic [R_W:0]   R_ONE = 25'd65536;
  localparam int DIV_VW      = 50;
  localparam int KELVIN_OFS  = 27315;
  localparam int TEMP_MAX    = 32767;

  typedef struct packed {
    logic [19:0] bridge_ohms;
    logic [19:0] nominal_ohms;
    logic [13:0] beta_kelvin;
    logic [13:0] full_scale_count;
    logic [15:0] reference_centikelvin;
    logic [2:0]  average_shift;
  } ntc_cfg_t;

  typedef enum logic [4:0] {
    BS_IDLE, BS_MUL_N, BS_MUL_D, BS_DIV_R, BS_LN, BS_DIV_U, BS_SQ, BS_TERM_DIV,
    BS_TERM_MUL, BS_BT_MUL, BS_BT_START, BS_DIV_BT, BS_D, BS_CHECK, BS_DIV_T,
    BS_FIN, BS_OUT
  } back_state_t;

endpackage

### design/ntc_front.sv
`timescale 1ns / 1ps
// Front end: accumulates raw samples and emits one average per block of samples.
// Depends on ntc_pkg.
module ntc_front #(
  parameter int ADC_BITS  = ntc_pkg::ADC_BITS_DEF,
  parameter int MAX_SHIFT = ntc_pkg::MAX_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [ADC_BITS-1:0] sample,
  input  logic [2:0]          shift,
  input  logic                clear,
  output logic                push,
  output logic [ADC_BITS-1:0] avg
);
  import ntc_pkg::*;

  localparam int SUM_W = ADC_BITS + MAX_SHIFT;
  localparam int CNT_W = MAX_SHIFT + 1;

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_add, target;

  always_comb begin
    sum_add = sum_r + SUM_W'(sample);
    cnt_add = cnt_r + CNT_W'(1);
    target  = CNT_W'(1) << shift;
    push    = accept && (cnt_add == target);
    avg     = ADC_BITS'(sum_add >> shift);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (clear) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (push) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (accept) begin
      sum_nxt = sum_add;
      cnt_nxt = cnt_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/ntc_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of averaged counts between the front end and the back end.
// Depends on ntc_pkg.
module ntc_fifo #(
  parameter int W = ntc_pkg::ADC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import ntc_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/ntc_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, divisor latched at start.
// Depends on ntc_pkg.
module ntc_div #(
  parameter int DW = 52,
  parameter int VW = ntc_pkg::DIV_VW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import ntc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [VW:0]   rem_r, shifted;
  logic [VW-1:0] dvs_r;
  logic [DW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r, ge;

  assign shifted  = {rem_r[VW-1:0], quo_r[DW-1]};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### design/ntc_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that turns one averaged count into a temperature and status.
// Depends on ntc_pkg and ntc_div.
module ntc_back #(
  parameter int ADC_BITS     = ntc_pkg::ADC_BITS_DEF,
  parameter int SERIES_TERMS = ntc_pkg::SERIES_TERMS_DEF,
  parameter int DW           = 52
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ntc_pkg::ntc_cfg_t    cfg,
  input  logic                 q_empty,
  input  logic [ADC_BITS-1:0]  q_avg,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_temp,
  output logic [1:0]           out_status
);
  import ntc_pkg::*;

  localparam int VW   = DIV_VW;
  localparam int NUM_W = 20 + ADC_BITS;
  localparam int A_W  = Q_FRAC + 1;
  localparam int ACC_W = 31;
  localparam int LN_W = 33;
  localparam int D_W  = VW + 2;
  localparam int KW   = (SERIES_TERMS > 2) ? $clog2(SERIES_TERMS) : 1;

  back_state_t st_r, st_nxt;

  logic [ADC_BITS-1:0]     avg_r, avg_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [R_W-1:0]          r_r, r_nxt;
  logic                    sat_r, sat_nxt, neg_r, neg_nxt;
  logic [A_W-1:0]          a2_r, a2_nxt, pow_r, pow_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic signed [LN_W-1:0]  lnr_r, lnr_nxt;
  logic [20:0]             btn_r, btn_nxt;
  logic signed [D_W-1:0]   d_r, d_nxt;
  logic signed [15:0]      temp_r, temp_nxt;
  logic [1:0]              stat_r, stat_nxt;

  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_q;
  logic [VW-1:0] div_dvs;

  logic [13:0]        fs_m_avg;
  logic [19:0]        nom;
  logic [15:0]        t0;
  logic [23:0]        diff;
  logic [2*A_W-1:0]   sq_prod, pow_prod;
  logic [A_W-1:0]     pow_new;
  logic [KW-1:0]      k_inc;
  logic [48:0]        num_t;
  logic               range_err, last_term;

  ntc_div #(.DW(DW), .VW(VW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // Shared datapath terms.
  always_comb begin
    fs_m_avg  = cfg.full_scale_count - 14'(avg_r);
    nom       = (cfg.nominal_ohms == '0) ? 20'd1 : cfg.nominal_ohms;
    t0        = (cfg.reference_centikelvin == '0) ? 16'd1 : cfg.reference_centikelvin;
    diff      = neg_r ? (24'(R_ONE) - r_r) : (r_r - 24'(R_ONE));
    sq_prod   = pow_r * pow_r;
    pow_prod  = pow_r * a2_r;
    pow_new   = A_W'(pow_prod >> Q_FRAC);
    k_inc     = k_r + KW'(1);
    num_t     = {btn_r, 28'd0};
    range_err = 14'(q_avg) >= cfg.full_scale_count;
    last_term = (k_r == KW'(SERIES_TERMS - 1));
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BS_IDLE:     if (!q_empty) st_nxt = range_err ? BS_OUT : BS_MUL_N;
      BS_MUL_N:    st_nxt = BS_MUL_D;
      BS_MUL_D:    st_nxt = BS_DIV_R;
      BS_DIV_R:    if (div_done) st_nxt = BS_LN;
      BS_LN:       st_nxt = (diff == '0) ? BS_BT_MUL : BS_DIV_U;
      BS_DIV_U:    if (div_done) st_nxt = BS_SQ;
      BS_SQ:       st_nxt = last_term ? BS_BT_MUL : BS_TERM_MUL;
      BS_TERM_DIV: if (div_done) st_nxt = last_term ? BS_BT_MUL : BS_TERM_MUL;
      BS_TERM_MUL: st_nxt = BS_TERM_DIV;
      BS_BT_MUL:   st_nxt = BS_BT_START;
      BS_BT_START: st_nxt = BS_DIV_BT;
      BS_DIV_BT:   if (div_done) st_nxt = BS_D;
      BS_D:        st_nxt = BS_CHECK;
      BS_CHECK:    st_nxt = (d_r <= 0) ? BS_OUT : BS_DIV_T;
      BS_DIV_T:    if (div_done) st_nxt = BS_FIN;
      BS_FIN:      st_nxt = BS_OUT;
      BS_OUT:      if (!out_stall) st_nxt = BS_IDLE;
      default:     st_nxt = BS_IDLE;
    endcase
  end

  // Control outputs: queue pop, divider launches, result handshake.
  always_comb begin
    q_pop     = (st_r == BS_IDLE) && !q_empty;
    out_valid = (st_r == BS_OUT);
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (st_r)
      BS_MUL_D: begin
        div_start = 1'b1;
        div_dvd   = DW'({num_r, 16'd0});
        div_dvs   = VW'(fs_m_avg) * VW'(nom);
      end
      BS_LN: begin
        div_start = (diff != '0);
        div_dvd   = DW'({diff, 28'd0});
        div_dvs   = VW'(r_r) + VW'(R_ONE);
      end
      BS_TERM_MUL: begin
        div_start = 1'b1;
        div_dvd   = DW'(pow_new);
        div_dvs   = VW'({k_inc, 1'b1});
      end
      BS_BT_START: begin
        div_start = 1'b1;
        div_dvd   = DW'(num_t);
        div_dvs   = VW'(t0);
      end
      BS_CHECK: begin
        div_start = (d_r > 0);
        div_dvd   = DW'(num_t) + DW'(d_r[D_W-2:1]);
        div_dvs   = d_r[VW-1:0];
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    avg_nxt  = avg_r;
    num_nxt  = num_r;
    r_nxt    = r_r;
    sat_nxt  = sat_r;
    neg_nxt  = neg_r;
    a2_nxt   = a2_r;
    pow_nxt  = pow_r;
    acc_nxt  = acc_r;
    k_nxt    = k_r;
    lnr_nxt  = lnr_r;
    btn_nxt  = btn_r;
    d_nxt    = d_r;
    temp_nxt = temp_r;
    stat_nxt = stat_r;
    case (st_r)
      BS_IDLE: begin
        avg_nxt  = q_avg;
        sat_nxt  = 1'b0;
        acc_nxt  = '0;
        k_nxt    = '0;
        temp_nxt = '0;
        stat_nxt = ST_RANGE;
      end
      BS_MUL_N: num_nxt = cfg.bridge_ohms * NUM_W'(avg_r);
      BS_DIV_R: if (div_done) begin
        if (div_q > DW'(R_MAX)) begin
          r_nxt   = R_MAX;
          sat_nxt = 1'b1;
        end else begin
          r_nxt = div_q[R_W-1:0];
        end
        neg_nxt = (div_q < DW'(R_ONE));
      end
      BS_DIV_U: if (div_done) pow_nxt = div_q[A_W-1:0];
      // The first series term is the magnitude itself.
      BS_SQ: begin
        a2_nxt  = A_W'(sq_prod >> Q_FRAC);
        acc_nxt = acc_r + ACC_W'(pow_r);
      end
      BS_TERM_DIV: if (div_done) acc_nxt = acc_r + ACC_W'(div_q[A_W-1:0]);
      BS_TERM_MUL: begin
        pow_nxt = pow_new;
        k_nxt   = k_inc;
      end
      BS_BT_MUL: begin
        btn_nxt = cfg.beta_kelvin * 21'd100;
        lnr_nxt = neg_r ? -$signed({1'b0, acc_r, 1'b0}) : $signed({1'b0, acc_r, 1'b0});
      end
      BS_D: d_nxt = $signed({2'b00, div_q[VW-1:0]}) + D_W'(lnr_r);
      BS_CHECK: if (d_r <= 0) begin
        temp_nxt = 16'(TEMP_MAX);
        stat_nxt = ST_SAT;
      end
      BS_FIN: begin
        if (div_q > DW'(TEMP_MAX + KELVIN_OFS)) begin
          temp_nxt = 16'(TEMP_MAX);
          stat_nxt = ST_SAT;
        end else begin
          temp_nxt = 16'(div_q[15:0] - 16'(KELVIN_OFS));
          stat_nxt = sat_r ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_temp   = temp_r;
  assign out_status = stat_r;

  always_ff @(posedge clk) begin
    avg_r  <= avg_nxt;
    num_r  <= num_nxt;
    r_r    <= r_nxt;
    sat_r  <= sat_nxt;
    neg_r  <= neg_nxt;
    a2_r   <= a2_nxt;
    pow_r  <= pow_nxt;
    acc_r  <= acc_nxt;
    k_r    <= k_nxt;
    lnr_r  <= lnr_nxt;
    btn_r  <= btn_nxt;
    d_r    <= d_nxt;
    temp_r <= temp_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BS_IDLE;
    else st_r <= st_nxt;
  end

endmodule

### design/ntc_thermistor_temperature_top.sv
`timescale 1ns / 1ps
// Top level of the NTC thermistor thermometer: configuration registers and wiring.
// Depends on ntc_pkg, ntc_front, ntc_fifo and ntc_back.
//
// Usage: raw ADC samples arrive on the in_ channel (in_valid / in_stall); every
// 2^average_shift samples form one average, which yields one request on the out_
// channel carrying the temperature in hundredths of a degree Celsius and a status.
// The front end accumulates samples at one per cycle and parks finished averages in
// a two-entry queue; it stalls the input only when that queue is full.
// The back end is a sequencer around one shared restoring divider (one quotient bit
// per cycle). An average takes (SERIES_TERMS + 3) divides, with control states between
// them, before its request is offered. A ratio of exactly one skips the series and
// finishes sooner; an out-of-range average is offered in the cycle after it is taken.
// A result waits in the output register while out_stall is high; the front end keeps
// taking samples meanwhile until the queue fills.
// Reset (rst_n low, synchronous) loads the default configuration and empties the
// accumulator, queue and sequencer. Configuration writes are always accepted
// (cfg_ready is high); a write to average_shift restarts the current average.
module ntc_thermistor_temperature_top #(
  parameter int ADC_BITS     = ntc_pkg::ADC_BITS_DEF,
  parameter int SERIES_TERMS = ntc_pkg::SERIES_TERMS_DEF,
  parameter int MAX_SHIFT    = ntc_pkg::MAX_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADC_BITS-1:0]              in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_temperature_centi_c,
  output logic [1:0]                       out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ntc_pkg::*;

  // Widest dividend: the ratio numerator or the series difference shifted by 28.
  localparam int DW = (ADC_BITS + 36 > 52) ? ADC_BITS + 36 : 52;

  ntc_cfg_t cfg_r, cfg_nxt;
  logic     cfg_we, shift_clr;
  logic     in_accept, f_push, q_pop, q_full, q_empty;
  logic [ADC_BITS-1:0] f_avg, q_avg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign shift_clr = cfg_we && (cfg_index == CFG_SHIFT);
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Register writes; the averaging shift is clamped to what the accumulator holds.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BRIDGE:  cfg_nxt.bridge_ohms           = cfg_data;
        CFG_NOMINAL: cfg_nxt.nominal_ohms          = cfg_data;
        CFG_BETA:    cfg_nxt.beta_kelvin           = cfg_data[13:0];
        CFG_FULL:    cfg_nxt.full_scale_count      = cfg_data[13:0];
        CFG_REF:     cfg_nxt.reference_centikelvin = cfg_data[15:0];
        CFG_SHIFT:   cfg_nxt.average_shift =
                       (32'(cfg_data[2:0]) > MAX_SHIFT) ? 3'(MAX_SHIFT) : cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bridge_ohms           <= 20'd32000;
      cfg_r.nominal_ohms          <= 20'd10000;
      cfg_r.beta_kelvin           <= 14'd3350;
      cfg_r.full_scale_count      <= 14'd4095;
      cfg_r.reference_centikelvin <= 16'd29815;
      cfg_r.average_shift         <= (MAX_SHIFT < 2) ? 3'(MAX_SHIFT) : 3'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ntc_front #(.ADC_BITS(ADC_BITS), .MAX_SHIFT(MAX_SHIFT)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(in_accept), .sample(in_sample),
    .shift(cfg_r.average_shift), .clear(shift_clr), .push(f_push), .avg(f_avg)
  );

  ntc_fifo #(.W(ADC_BITS)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_push), .wdata(f_avg), .pop(q_pop),
    .rdata(q_avg), .full(q_full), .empty(q_empty)
  );

  ntc_back #(.ADC_BITS(ADC_BITS), .SERIES_TERMS(SERIES_TERMS), .DW(DW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_avg(q_avg),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_temp(out_temperature_centi_c), .out_status(out_status)
  );

`ifndef SYNTHESIS
  // The front end must never push an average into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full) else $error("average pushed into full queue");

  // The back end must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // A range error always reports a zero temperature.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_RANGE) |-> (out_temperature_centi_c == 16'sd0))
    else $error("range error with nonzero temperature");
`endif

endmodule
